[src/tbrl_pkg.sv]
// Shared types and constants of the token bucket rate limiter.
package tbrl_pkg;

    localparam int SLOT_W    = 8;
    localparam int NOW_W     = 32;
    localparam int MAXREQ_W  = 16;
    localparam int WIN_W     = 24;
    localparam int LEVEL_W   = 40;
    localparam int ADD_W     = NOW_W + MAXREQ_W;
    localparam int SUM_W     = ADD_W + 1;
    localparam int RETRY_W   = 15;
    localparam int SCALE_W   = 10;
    localparam int DVS_W     = MAXREQ_W + SCALE_W;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = WIN_W;
    localparam int IN_SLOTS  = 2 ** SLOT_W;

    localparam int SLOTS_DEF = 256;

    localparam logic [MAXREQ_W-1:0] MAXREQ_RST   = MAXREQ_W'(10);
    localparam logic [WIN_W-1:0]    WIN_RST      = WIN_W'(1000);
    localparam logic [SCALE_W-1:0]  MS_PER_S     = SCALE_W'(1000);

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_MAX_REQ   = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_WINDOW_MS = CFG_AW'(1);

    typedef struct packed {
        logic [SLOT_W-1:0] client_slot;
        logic [NOW_W-1:0]  now_ms;
    } t_req;

    typedef struct packed {
        logic               allowed;
        logic [RETRY_W-1:0] retry_after_s;
    } t_rsp;

    // One bucket as it lies in the state memory.
    typedef struct packed {
        logic               seen;
        logic [LEVEL_W-1:0] level;
        logic [NOW_W-1:0]   last_ms;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[src/token_bucket_rate_limiter.sv]
// Token bucket rate limiter: one bucket per memory index (client slot modulo SLOTS), kept in a state memory.
// Steps: memory read on the accepted word, then S_LOAD, S_MUL, S_SAT, S_DEC (write-back),
// S_DIV for a refused request only (24-bit serial divider), and S_DONE to the result word.
// One request in flight; the next word is taken once the result word is registered,
// or later still while the result word of the request before is still waiting.
// Reset: after reset a clearing pass writes every one of the SLOTS memory
// entries, one per cycle, and no request word is taken until it ends.
module token_bucket_rate_limiter
    import tbrl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rsp              o_data,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int IW = $clog2(SLOTS);

    typedef logic [IW-1:0] t_mod_tab [IN_SLOTS];

    // Slot number to memory index, reduced modulo SLOTS without a divider.
    function automatic t_mod_tab f_mod_tab();
        t_mod_tab tab;
        int       j;
        j = 0;
        for (int i = 0; i < IN_SLOTS; i++) begin
            tab[i] = IW'(j);
            j = (j == SLOTS - 1) ? 0 : j + 1;
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = f_mod_tab();

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SAT,
        S_DEC,
        S_DIV,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [IW-1:0]        r_clr_addr;
    logic [IW-1:0]        r_idx;
    logic [NOW_W-1:0]     r_now;
    logic [LEVEL_W-1:0]   r_cap;
    logic [DVS_W-1:0]     r_dvs;
    logic [LEVEL_W-1:0]   r_level;
    logic [NOW_W-1:0]     r_last;
    logic [NOW_W-1:0]     r_elapsed;
    logic                 r_refill;
    logic [ADD_W-1:0]     r_add;
    logic                 r_allow;
    logic [WIN_W-1:0]     r_quot;
    logic                 r_o_valid;
    t_rsp                 r_o_rsp;
    logic [MAXREQ_W-1:0]  r_max_req;
    logic [WIN_W-1:0]     r_window;

    logic [MAXREQ_W-1:0]  eff_max;
    logic [WIN_W-1:0]     eff_win;
    logic [LEVEL_W-1:0]   win_lvl;
    logic                 accept;
    logic                 short;
    logic [SUM_W-1:0]     n_sum;
    logic [LEVEL_W-1:0]   n_wr_level;
    t_entry               rd_entry;
    t_entry               wr_entry;
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 div_start;
    logic                 div_done;
    logic [WIN_W-1:0]     div_quot;

    // A register written as zero acts as one.
    assign eff_max = (r_max_req == '0) ? MAXREQ_W'(1) : r_max_req;
    assign eff_win = (r_window == '0) ? WIN_W'(1) : r_window;
    assign win_lvl = LEVEL_W'(eff_win);

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign short   = (r_level < win_lvl);
    assign n_sum   = SUM_W'(r_level) + SUM_W'(r_add);

    assign n_wr_level = short ? r_level : (r_level - win_lvl);
    assign rd_entry   = t_entry'(ram_rdata);

    always_comb begin
        wr_entry.seen    = 1'b1;
        wr_entry.level   = n_wr_level;
        wr_entry.last_ms = r_last;
    end

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_DEC);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : ENTRY_W'(wr_entry);
    assign div_start = (r_state == S_DEC) && short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= MAXREQ_RST;
            r_window  <= WIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_REQ:   r_max_req <= i_cfg_wdata[MAXREQ_W-1:0];
                CFG_WINDOW_MS: r_window  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // In S_DONE the output register is handled by the state itself.
            if (r_o_valid && i_ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == IW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx   <= MOD_TAB[i_data.client_slot];
                        r_now   <= i_data.now_ms;
                        r_cap   <= LEVEL_W'(eff_max) * LEVEL_W'(eff_win);
                        r_dvs   <= DVS_W'(eff_max) * DVS_W'(MS_PER_S);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // A bucket not seen since reset starts full at this time stamp.
                    if (!rd_entry.seen) begin
                        r_level  <= r_cap;
                        r_last   <= r_now;
                        r_refill <= 1'b0;
                    end else begin
                        r_level <= rd_entry.level;
                        if (r_now > rd_entry.last_ms) begin
                            r_elapsed <= r_now - rd_entry.last_ms;
                            r_last    <= r_now;
                            r_refill  <= 1'b1;
                        end else begin
                            r_last   <= rd_entry.last_ms;
                            r_refill <= 1'b0;
                        end
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_add   <= ADD_W'(r_elapsed) * ADD_W'(eff_max);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // Clipping at the capacity happens only when time moved on.
                    if (r_refill) begin
                        r_level <= (n_sum > SUM_W'(r_cap)) ? r_cap : n_sum[LEVEL_W-1:0];
                    end
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_allow <= !short;
                    r_state <= short ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_quot  <= div_quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid               <= 1'b1;
                        r_o_rsp.allowed         <= r_allow;
                        r_o_rsp.retry_after_s   <= r_allow ? '0 :
                                                   RETRY_W'(r_quot + WIN_W'(1));
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_rsp;

    tbrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (MOD_TAB[i_data.client_slot]),
        .o_rdata (ram_rdata)
    );

    tbrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (WIN_W'(win_lvl - r_level)),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("request word taken during the clearing pass");

    a_accept_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOAD))
        else $error("accepted word did not start a memory read");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DEC) && ram_we) |=> !ram_we || (r_state == S_CLEAR))
        else $error("bucket written back twice for one request");

    a_allowed_no_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.allowed) |-> (o_data.retry_after_s == '0))
        else $error("passed request carries a retry time");
`endif

endmodule

[src/tbrl_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module tbrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/tbrl_div.sv]
// Restoring serial divider for the retry time, one quotient bit per cycle.
module tbrl_div
    import tbrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIN_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [WIN_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(WIN_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [WIN_W-1:0] r_dvd;

    logic [DVS_W:0]   n_trial;
    logic             n_qbit;
    logic [DVS_W-1:0] n_rem;

    // The partial remainder stays below the divisor, so one shifted bit fits.
    always_comb begin
        n_trial = {r_rem, r_dvd[WIN_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_dvs});
        n_rem   = n_qbit ? DVS_W'(n_trial - {1'b0, r_dvs}) : n_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIN_W - 1);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_dvd  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[WIN_W-2:0], n_qbit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule
